// ===== src/assert_macros.svh =====
// Assertion macros used by the parser result queue
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Check that a trigger implies a condition in the same cycle
`define ASSERT_IMPLIES(label, trig, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (expr)) else $error(msg);

`endif

// ===== src/bmp_pkg.sv =====
// Types, constants and helpers for the BMP stream parser
`default_nettype none
package bmp_pkg;

  localparam int unsigned MAX_WIDTH   = 4096;
  localparam int unsigned MAX_HEIGHT  = 4096;
  localparam int unsigned MAX_PALETTE = 256;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);

  localparam logic [2:0] KIND_HEADER  = 3'd0;
  localparam logic [2:0] KIND_PALETTE = 3'd1;
  localparam logic [2:0] KIND_PIXEL   = 3'd2;
  localparam logic [2:0] KIND_DONE    = 3'd3;
  localparam logic [2:0] KIND_ERROR   = 3'd4;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_SIGNATURE = 3'd1;
  localparam logic [2:0] ERR_DIB_SIZE  = 3'd2;
  localparam logic [2:0] ERR_PLANES    = 3'd3;
  localparam logic [2:0] ERR_BPP       = 3'd4;
  localparam logic [2:0] ERR_RANGE     = 3'd5;
  localparam logic [2:0] ERR_OFFSET    = 3'd6;
  localparam logic [2:0] ERR_TRUNC     = 3'd7;

  typedef enum logic [1:0] {
    PH_HEADER   = 2'd0,
    PH_PALETTE  = 2'd1,
    PH_PIXELS   = 2'd2,
    PH_FINISHED = 2'd3
  } phase_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [11:0] row;
    logic [11:0] col;
    logic [31:0] value;
    logic [12:0] width;
    logic [12:0] height;
    logic [5:0]  bits_per_pixel;
    logic [2:0]  error_code;
    logic        run_end;
  } result_t;

  // Build one result beat with run_end clear
  function automatic result_t mk_res(input logic [2:0] kind, input logic [11:0] row,
                                     input logic [11:0] col, input logic [31:0] value,
                                     input logic [12:0] w, input logic [12:0] h,
                                     input logic [5:0] bpp, input logic [2:0] err);
    result_t r;
    r.kind = kind;
    r.row = row;
    r.col = col;
    r.value = value;
    r.width = w;
    r.height = h;
    r.bits_per_pixel = bpp;
    r.error_code = err;
    r.run_end = 1'b0;
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== src/bmp_stream_parser.sv =====
// Top level of the streaming BMP parser
//
//  channel | direction | fields                                     | handshake
//  input   | in        | byte_value, last                           | in_valid / in_stall
//  output  | out       | kind,row,col,value,width,height,           | out_valid / out_stall
//          |           | bits_per_pixel,error_code,run_end          |
//
// One byte is taken per cycle while the input is not stalled; each byte yields zero, one or two result beats.
// The parser registers update in the cycle the byte is taken; its beats are written
// into a four-entry result queue and reach the output port from there.
// Input stalls while the queue has fewer than two free entries.
// Output beats drain one per cycle while out_stall is low; reset is synchronous and empties the queue.
`default_nettype none
module bmp_stream_parser (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  byte_value,
  input  wire logic        last,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       kind,
  output logic [11:0]      row,
  output logic [11:0]      col,
  output logic [31:0]      value,
  output logic [12:0]      width,
  output logic [12:0]      height,
  output logic [5:0]       bits_per_pixel,
  output logic [2:0]       error_code,
  output logic             run_end
);
  import bmp_pkg::*;

  result_t res_a, res_b, head;
  logic    va, vb, room, take;

  assign in_stall = !room;
  assign take     = in_valid && room;

  bmp_front u_front (
    .clk(clk), .rst(rst), .take(take), .byte_value(byte_value), .last(last),
    .res_a(res_a), .res_b(res_b), .va(va), .vb(vb)
  );

  bmp_queue u_queue (
    .clk(clk), .rst(rst), .push_a(take && va), .push_b(take && vb),
    .din_a(res_a), .din_b(res_b), .room(room),
    .out_valid(out_valid), .out_stall(out_stall), .dout(head)
  );

  // Drive result fields from the queue head
  assign kind           = head.kind;
  assign row            = head.row;
  assign col            = head.col;
  assign value          = head.value;
  assign width          = head.width;
  assign height         = head.height;
  assign bits_per_pixel = head.bits_per_pixel;
  assign error_code     = head.error_code;
  assign run_end        = head.run_end;

endmodule
`default_nettype wire

// ===== src/bmp_front.sv =====
// Byte parser: classifies each file byte and produces up to two result beats
`default_nettype none
module bmp_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           take,
  input  wire logic [7:0]     byte_value,
  input  wire logic           last,
  output bmp_pkg::result_t    res_a,
  output bmp_pkg::result_t    res_b,
  output logic                va,
  output logic                vb
);
  import bmp_pkg::*;

  logic [31:0] pos, pos_next;
  logic [31:0] acc, acc_next;
  logic [31:0] poff, poff_next;
  logic [12:0] iw, iw_next, ih, ih_next;
  logic [5:0]  dep, dep_next;
  logic [8:0]  pcnt, pcnt_next, pidx, pidx_next;
  logic [12:0] rowc, rowc_next, colc, colc_next;
  logic [1:0]  bii, bii_next, pad, pad_next;
  phase_t      phase, phase_next;

  logic        low_pos, field_a, field_b, stop;
  logic [5:0]  p6;
  logic [1:0]  sidx;
  logic [31:0] bx;
  logic [10:0] need;
  logic [2:0]  nb;
  logic [8:0]  cnt;
  logic [1:0]  low2;

  // Work out next state and result beats for one byte
  always_comb begin
    pos_next = pos; acc_next = acc; poff_next = poff;
    iw_next = iw; ih_next = ih; dep_next = dep;
    pcnt_next = pcnt; pidx_next = pidx; rowc_next = rowc; colc_next = colc;
    bii_next = bii; pad_next = pad; phase_next = phase;
    res_a = '0; res_b = '0; va = 1'b0; vb = 1'b0;
    stop = 1'b0;
    bx = {24'b0, byte_value};
    p6 = pos[5:0];
    low_pos = (pos[31:6] == 26'd0);
    field_a = low_pos && ((p6 >= 6'd10 && p6 <= 6'd25) || (p6 >= 6'd46 && p6 <= 6'd49));
    field_b = low_pos && p6 >= 6'd26 && p6 <= 6'd29;
    sidx = field_a ? (p6[1:0] + 2'd2) : {1'b0, p6[0]};
    need = 11'd54 + {pcnt, 2'b00};
    nb = dep[5:3];
    cnt = 9'd0;
    low2 = 2'd0;

    if (pos != 32'hFFFF_FFFF) pos_next = pos + 32'd1;

    case (phase)
      PH_HEADER: begin
        if (low_pos && p6 == 6'd0 && byte_value != 8'h42) begin
          res_a = mk_res(KIND_ERROR, '0, '0, '0, '0, '0, '0, ERR_SIGNATURE);
          va = 1'b1; phase_next = PH_FINISHED; stop = 1'b1;
        end else if (low_pos && p6 == 6'd1 && byte_value != 8'h4D) begin
          res_a = mk_res(KIND_ERROR, '0, '0, '0, '0, '0, '0, ERR_SIGNATURE);
          va = 1'b1; phase_next = PH_FINISHED; stop = 1'b1;
        end
        if (!stop) begin
          if (field_a || field_b) begin
            if (sidx == 2'd0) acc_next = bx;
            else acc_next = acc | (bx << {sidx, 3'b000});
          end
          if (low_pos) begin
            case (p6)
              6'd13: poff_next = acc_next;
              6'd17: begin
                if (acc_next != 32'd40) begin
                  res_a = mk_res(KIND_ERROR, '0, '0, '0, '0, '0, '0, ERR_DIB_SIZE);
                  va = 1'b1; phase_next = PH_FINISHED;
                end
              end
              6'd21: begin
                if (acc_next > MAX_WIDTH) begin
                  res_a = mk_res(KIND_ERROR, '0, '0, '0, '0, '0, '0, ERR_RANGE);
                  va = 1'b1; phase_next = PH_FINISHED;
                end else iw_next = acc_next[12:0];
              end
              6'd25: begin
                if (acc_next > MAX_HEIGHT) begin
                  res_a = mk_res(KIND_ERROR, '0, '0, '0, '0, '0, '0, ERR_RANGE);
                  va = 1'b1; phase_next = PH_FINISHED;
                end else ih_next = acc_next[12:0];
              end
              6'd27: begin
                if (acc_next != 32'd1) begin
                  res_a = mk_res(KIND_ERROR, '0, '0, '0, '0, '0, '0, ERR_PLANES);
                  va = 1'b1; phase_next = PH_FINISHED;
                end
              end
              6'd29: begin
                if (acc_next != 32'd8 && acc_next != 32'd16 &&
                    acc_next != 32'd24 && acc_next != 32'd32) begin
                  res_a = mk_res(KIND_ERROR, '0, '0, '0, '0, '0, '0, ERR_BPP);
                  va = 1'b1; phase_next = PH_FINISHED;
                end else dep_next = acc_next[5:0];
              end
              6'd49: begin
                if (dep == 6'd8) begin
                  if (acc_next > MAX_PALETTE) begin
                    res_a = mk_res(KIND_ERROR, '0, '0, '0, '0, '0, '0, ERR_RANGE);
                    va = 1'b1; phase_next = PH_FINISHED;
                  end else begin
                    cnt = (acc_next == 32'd0) ? 9'd256 : acc_next[8:0];
                    pcnt_next = cnt;
                  end
                end else pcnt_next = 9'd0;
              end
              6'd53: begin
                if (poff < {21'b0, need}) begin
                  res_a = mk_res(KIND_ERROR, '0, '0, '0, '0, '0, '0, ERR_OFFSET);
                  va = 1'b1; phase_next = PH_FINISHED;
                end else begin
                  res_a = mk_res(KIND_HEADER, '0, '0, '0, iw, ih, dep, ERR_NONE);
                  va = 1'b1;
                  acc_next = '0; bii_next = '0;
                  if (dep == 6'd8) begin
                    phase_next = PH_PALETTE; pidx_next = '0;
                  end else begin
                    rowc_next = '0; colc_next = '0; pad_next = '0;
                    if (iw == 13'd0 || ih == 13'd0) begin
                      res_b = mk_res(KIND_DONE, '0, '0, '0, '0, '0, '0, ERR_NONE);
                      vb = 1'b1; phase_next = PH_FINISHED;
                    end else phase_next = PH_PIXELS;
                  end
                end
              end
              default: ;
            endcase
          end
        end
      end

      PH_PALETTE: begin
        if (bii == 2'd0) acc_next = bx;
        else acc_next = acc | (bx << {bii, 3'b000});
        if (bii == 2'd3) begin
          res_a = mk_res(KIND_PALETTE, '0, {3'b0, pidx}, acc_next, '0, '0, '0, ERR_NONE);
          va = 1'b1;
          bii_next = '0;
          pidx_next = pidx + 9'd1;
          if (pidx_next >= pcnt) begin
            rowc_next = '0; colc_next = '0; pad_next = '0; acc_next = '0;
            if (iw == 13'd0 || ih == 13'd0) begin
              res_b = mk_res(KIND_DONE, '0, '0, '0, '0, '0, '0, ERR_NONE);
              vb = 1'b1; phase_next = PH_FINISHED;
            end else phase_next = PH_PIXELS;
          end
        end else bii_next = bii + 2'd1;
      end

      PH_PIXELS: begin
        if (pos < poff) begin
          // skip gap before the pixel array
        end else if (pad != 2'd0) begin
          pad_next = pad - 2'd1;
        end else begin
          if (bii == 2'd0) acc_next = bx;
          else acc_next = acc | (bx << {bii, 3'b000});
          if ({1'b0, bii} + 3'd1 >= nb) begin
            res_a = mk_res(KIND_PIXEL, rowc[11:0], colc[11:0], acc_next,
                           '0, '0, '0, ERR_NONE);
            va = 1'b1;
            bii_next = '0; acc_next = '0;
            colc_next = colc + 13'd1;
            if (colc_next >= iw) begin
              colc_next = '0;
              rowc_next = rowc + 13'd1;
              if (rowc_next >= ih) begin
                res_b = mk_res(KIND_DONE, '0, '0, '0, '0, '0, '0, ERR_NONE);
                vb = 1'b1; phase_next = PH_FINISHED;
              end else begin
                low2 = nb[1:0] * iw[1:0];
                pad_next = 2'd0 - low2;
              end
            end
          end else bii_next = bii + 2'd1;
        end
      end

      default: ;
    endcase

    // Close the file on the last mark
    if (last) begin
      if (phase_next != PH_FINISHED) begin
        if (!va) begin
          res_a = mk_res(KIND_ERROR, '0, '0, '0, '0, '0, '0, ERR_TRUNC); va = 1'b1;
        end else begin
          res_b = mk_res(KIND_ERROR, '0, '0, '0, '0, '0, '0, ERR_TRUNC); vb = 1'b1;
        end
      end
      pos_next = '0; acc_next = '0; poff_next = '0; iw_next = '0; ih_next = '0;
      dep_next = '0; pcnt_next = '0; pidx_next = '0; rowc_next = '0; colc_next = '0;
      bii_next = '0; pad_next = '0; phase_next = PH_HEADER;
    end

    // Mark the final beat of this byte
    if (vb) res_b.run_end = 1'b1;
    else if (va) res_a.run_end = 1'b1;
  end

  // Advance parser state on each accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0; acc <= '0; poff <= '0; iw <= '0; ih <= '0; dep <= '0;
      pcnt <= '0; pidx <= '0; rowc <= '0; colc <= '0; bii <= '0; pad <= '0;
      phase <= PH_HEADER;
    end else if (take) begin
      pos <= pos_next; acc <= acc_next; poff <= poff_next; iw <= iw_next;
      ih <= ih_next; dep <= dep_next; pcnt <= pcnt_next; pidx <= pidx_next;
      rowc <= rowc_next; colc <= colc_next; bii <= bii_next; pad <= pad_next;
      phase <= phase_next;
    end
  end

endmodule
`default_nettype wire

// ===== src/bmp_queue.sv =====
// Result queue: two writes and one read per cycle between parser and output
`default_nettype none
`include "assert_macros.svh"
module bmp_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push_a,
  input  wire logic              push_b,
  input  bmp_pkg::result_t       din_a,
  input  bmp_pkg::result_t       din_b,
  output logic                   room,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output bmp_pkg::result_t       dout
);
  import bmp_pkg::*;

  result_t        mem [QDEPTH];
  logic [QAW-1:0] wr, rd;
  logic [QAW:0]   count, count_next;
  logic           pop;
  logic [QAW-1:0] wr_b;

  assign pop       = out_valid && !out_stall;
  assign out_valid = (count != '0);
  assign room      = (count <= (QAW+1)'(QDEPTH - 2));
  assign dout      = mem[rd];
  assign wr_b      = push_a ? wr + QAW'(1) : wr;

  always_comb begin
    count_next = count + (QAW+1)'(push_a) + (QAW+1)'(push_b) - (QAW+1)'(pop);
  end

  // Store beats in order
  always_ff @(posedge clk) begin
    if (push_a) mem[wr] <= din_a;
    if (push_b) mem[wr_b] <= din_b;
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr <= '0; rd <= '0; count <= '0;
    end else begin
      wr <= wr + QAW'(push_a) + QAW'(push_b);
      if (pop) rd <= rd + QAW'(1);
      count <= count_next;
    end
  end

  `ASSERT_ALWAYS(a_count_max, count <= (QAW+1)'(QDEPTH), "queue overflow")
  `ASSERT_IMPLIES(a_push_room, push_a || push_b, room, "push without room")
  `ASSERT_IMPLIES(a_b_needs_a, push_b, push_a, "second beat without first")

endmodule
`default_nettype wire

// ===== bench/tb_bmp_stream_parser.sv =====
// Testbench for the streaming BMP parser: directed files, random files, idling and back-pressure
`timescale 1ns / 100ps
`default_nettype none
module tb_bmp_stream_parser;
  import bmp_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  byte_value = 8'd0;
  logic        last = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  kind;
  logic [11:0] row;
  logic [11:0] col;
  logic [31:0] value;
  logic [12:0] width;
  logic [12:0] height;
  logic [5:0]  bits_per_pixel;
  logic [2:0]  error_code;
  logic        run_end;

  bmp_stream_parser DUT (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .byte_value(byte_value), .last(last), .out_valid(out_valid), .out_stall(out_stall),
    .kind(kind), .row(row), .col(col), .value(value), .width(width), .height(height),
    .bits_per_pixel(bits_per_pixel), .error_code(error_code), .run_end(run_end)
  );

  // Decoder state mirrored by the predictor
  logic [31:0] pos_q, acc_q, offs_q;
  logic [12:0] wid_q, hgt_q;
  logic [5:0]  bpp_q;
  logic [8:0]  pal_cnt_q, pal_idx_q;
  logic [12:0] row_q, col_q;
  logic [1:0]  sub_q, pad_q;
  phase_t      phase_q;

  result_t expected_beats[$];
  result_t step_beats[$];
  int      fail_count = 0;
  int      send_idle_pct = 0;
  int      recv_idle_pct = 0;
  int      hold_cycles = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic result_t beat(logic [2:0] k, logic [11:0] r, logic [11:0] c,
                                   logic [31:0] v, logic [12:0] w, logic [12:0] h,
                                   logic [5:0] b, logic [2:0] e);
    result_t x;
    x.kind = k; x.row = r; x.col = c; x.value = v; x.width = w; x.height = h;
    x.bits_per_pixel = b; x.error_code = e; x.run_end = 1'b0;
    return x;
  endfunction

  // Append one beat to the results of the current byte
  function automatic void add_beat(result_t x);
    step_beats.insert(step_beats.size(), x);
  endfunction

  function automatic void clear_decoder();
    pos_q = '0; acc_q = '0; offs_q = '0; wid_q = '0; hgt_q = '0; bpp_q = '0;
    pal_cnt_q = '0; pal_idx_q = '0; row_q = '0; col_q = '0; sub_q = '0; pad_q = '0;
    phase_q = PH_HEADER;
  endfunction

  function automatic void raise_error(logic [2:0] code);
    phase_q = PH_FINISHED;
    add_beat(beat(KIND_ERROR, '0, '0, '0, '0, '0, '0, code));
  endfunction

  function automatic void enter_pixels();
    row_q = '0; col_q = '0; sub_q = '0; pad_q = '0; acc_q = '0;
    if (wid_q == 0 || hgt_q == 0) begin
      phase_q = PH_FINISHED;
      add_beat(beat(KIND_DONE, '0, '0, '0, '0, '0, '0, ERR_NONE));
    end else begin
      phase_q = PH_PIXELS;
    end
  endfunction

  function automatic void merge_byte(logic [1:0] lane, logic [7:0] b);
    if (lane == 0) acc_q = {24'd0, b};
    else acc_q = acc_q | ({24'd0, b} << (8 * lane));
  endfunction

  // Header bytes: collect fields and check each on its final byte
  function automatic void decode_header(logic [31:0] p, logic [7:0] b);
    int unsigned first;
    int unsigned cnt;
    first = 0;
    if (p >= 10 && p <= 29) first = (p < 14) ? 10 : (p < 18) ? 14 : (p < 22) ? 18 :
                                    (p < 26) ? 22 : (p < 28) ? 26 : 28;
    else if (p >= 46 && p <= 49) first = 46;
    if ((p == 0 && b != 8'h42) || (p == 1 && b != 8'h4D)) begin
      raise_error(ERR_SIGNATURE);
      return;
    end
    if (first != 0) merge_byte(2'(p - first), b);
    case (p)
      13: offs_q = acc_q;
      17: if (acc_q != 40) raise_error(ERR_DIB_SIZE);
      21: if (acc_q > MAX_WIDTH) raise_error(ERR_RANGE); else wid_q = acc_q[12:0];
      25: if (acc_q > MAX_HEIGHT) raise_error(ERR_RANGE); else hgt_q = acc_q[12:0];
      27: if (acc_q != 1) raise_error(ERR_PLANES);
      29: begin
        if (acc_q != 8 && acc_q != 16 && acc_q != 24 && acc_q != 32) raise_error(ERR_BPP);
        else bpp_q = acc_q[5:0];
      end
      49: begin
        if (bpp_q == 8) begin
          cnt = (acc_q == 0) ? 256 : acc_q;
          if (cnt > MAX_PALETTE) raise_error(ERR_RANGE); else pal_cnt_q = cnt[8:0];
        end else begin
          pal_cnt_q = '0;
        end
      end
      53: begin
        if (offs_q < 54 + 4 * pal_cnt_q) begin
          raise_error(ERR_OFFSET);
        end else begin
          add_beat(beat(KIND_HEADER, '0, '0, '0, wid_q, hgt_q, bpp_q, ERR_NONE));
          if (bpp_q == 8) begin
            phase_q = PH_PALETTE; pal_idx_q = '0; sub_q = '0; acc_q = '0;
          end else begin
            enter_pixels();
          end
        end
      end
      default: ;
    endcase
  endfunction

  // Work out the beats caused by one accepted byte
  function automatic void decode_byte(logic [7:0] b, logic lst);
    logic [31:0] p;
    int unsigned nb;
    p = pos_q;
    step_beats.delete();
    if (pos_q != 32'hFFFF_FFFF) pos_q++;
    case (phase_q)
      PH_HEADER: decode_header(p, b);
      PH_PALETTE: begin
        merge_byte(sub_q, b);
        if (sub_q == 3) begin
          add_beat(beat(KIND_PALETTE, '0, 12'(pal_idx_q), acc_q, '0, '0, '0, ERR_NONE));
          sub_q = '0;
          pal_idx_q++;
          if (pal_idx_q >= pal_cnt_q) enter_pixels();
        end else begin
          sub_q++;
        end
      end
      PH_PIXELS: begin
        nb = bpp_q >> 3;
        if (p < offs_q) begin
          // skip the gap before the pixel array
        end else if (pad_q != 0) begin
          pad_q--;
        end else begin
          merge_byte(sub_q, b);
          if (sub_q + 1 >= nb) begin
            add_beat(beat(KIND_PIXEL, row_q[11:0], col_q[11:0], acc_q,
                          '0, '0, '0, ERR_NONE));
            sub_q = '0; acc_q = '0;
            col_q++;
            if (col_q >= wid_q) begin
              col_q = '0;
              row_q++;
              if (row_q >= hgt_q) begin
                phase_q = PH_FINISHED;
                add_beat(beat(KIND_DONE, '0, '0, '0, '0, '0, '0, ERR_NONE));
              end else begin
                pad_q = 2'((4 - ((nb * wid_q) & 3)) & 3);
              end
            end
          end else begin
            sub_q++;
          end
        end
      end
      default: ;
    endcase
    if (lst) begin
      if (phase_q != PH_FINISHED) raise_error(ERR_TRUNC);
      clear_decoder();
    end
    if (step_beats.size() > 0) step_beats[step_beats.size() - 1].run_end = 1'b1;
    foreach (step_beats[i]) expected_beats.insert(expected_beats.size(), step_beats[i]);
  endfunction

  // Offer one byte and hold it until accepted; valid stays up for a following byte
  task automatic send_byte(logic [7:0] b, logic lst);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    byte_value <= b;
    last <= lst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    decode_byte(b, lst);
  endtask

  task automatic send_file(const ref logic [7:0] bytes[$]);
    foreach (bytes[i]) send_byte(bytes[i], i == bytes.size() - 1);
  endtask

  // Drop valid and wait until every expected beat has come
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Receiver stall pattern, with an optional long hold-off
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Compare each accepted beat with the oldest expectation
  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_beats.size() == 0) begin
        $error("unexpected beat kind=%0d", kind);
        fail_count++;
      end else begin
        want = expected_beats.pop_front();
        if (kind != want.kind) begin
          $error("kind exp %0d got %0d", want.kind, kind); fail_count++;
        end
        if (row != want.row) begin
          $error("row exp %0d got %0d", want.row, row); fail_count++;
        end
        if (col != want.col) begin
          $error("col exp %0d got %0d", want.col, col); fail_count++;
        end
        if (value != want.value) begin
          $error("value exp %h got %h", want.value, value); fail_count++;
        end
        if (width != want.width) begin
          $error("width exp %0d got %0d", want.width, width); fail_count++;
        end
        if (height != want.height) begin
          $error("height exp %0d got %0d", want.height, height); fail_count++;
        end
        if (bits_per_pixel != want.bits_per_pixel) begin
          $error("bits_per_pixel exp %0d got %0d", want.bits_per_pixel, bits_per_pixel);
          fail_count++;
        end
        if (error_code != want.error_code) begin
          $error("error_code exp %0d got %0d", want.error_code, error_code); fail_count++;
        end
        if (run_end != want.run_end) begin
          $error("run_end exp %0d got %0d", want.run_end, run_end); fail_count++;
        end
      end
    end
  end

  function automatic void put_le(ref logic [7:0] q[$], input logic [31:0] v, input int n);
    for (int i = 0; i < n; i++) q.insert(q.size(), v[8 * i +: 8]);
  endfunction

  // Build a well-formed file; dmg picks one header fault, trunc cuts bytes off the end
  function automatic void build_file(ref logic [7:0] q[$], input int w, input int h,
                                     input int bpp, input int pal, input int gap,
                                     input int dmg, input int trunc, input int tail);
    int cnt, offs, nb, pad;
    q.delete();
    cnt = (bpp == 8) ? ((pal == 0) ? 256 : pal) : 0;
    offs = 54 + 4 * cnt + gap;
    if (dmg == 6) offs = 54 + 4 * cnt - 1 - $urandom_range(3);
    nb = bpp / 8;
    pad = (4 - ((nb * w) & 3)) & 3;
    q.insert(q.size(), dmg == 1 ? 8'h42 ^ (8'h1 << $urandom_range(7)) : 8'h42);
    q.insert(q.size(), dmg == 7 ? 8'h4D ^ (8'h1 << $urandom_range(7)) : 8'h4D);
    put_le(q, $urandom, 8);
    put_le(q, offs, 4);
    put_le(q, dmg == 2 ? 40 + $urandom_range(1, 200) : 40, 4);
    put_le(q, dmg == 5 ? 4097 + $urandom_range(100000) : w, 4);
    put_le(q, dmg == 8 ? $urandom | 32'h8000_0000 : h, 4);
    put_le(q, dmg == 3 ? 2 + $urandom_range(100) : 1, 2);
    put_le(q, dmg == 4 ? 24 + 1 : bpp, 2);
    put_le(q, $urandom, 16);
    put_le(q, dmg == 9 ? 257 + $urandom_range(5000) : pal, 4);
    put_le(q, $urandom, 4);
    for (int i = 0; i < 4 * cnt + gap; i++) q.insert(q.size(), 8'($urandom));
    for (int r = 0; r < h; r++) begin
      for (int i = 0; i < nb * w + pad; i++) q.insert(q.size(), 8'($urandom));
    end
    for (int i = 0; i < tail; i++) q.insert(q.size(), 8'($urandom));
    for (int i = 0; i < trunc && q.size() > 1; i++) void'(q.pop_back());
  endfunction

  task automatic test_directed();
    logic [7:0] f[$];
    int bpps[4] = '{8, 16, 24, 32};
    // every depth, an odd width for padding
    foreach (bpps[i]) begin
      build_file(f, 3, 2, bpps[i], 2, 1, 0, 0, 2);
      send_file(f);
    end
    // every header fault, file cut right after the header
    for (int d = 1; d <= 9; d++) begin
      build_file(f, 1, 1, 8, 1, 0, d, 8, 0);
      send_file(f);
    end
    // full palette from a zero count, cut short inside the palette
    build_file(f, 1, 1, 8, 0, 0, 0, 1020, 0); send_file(f);
    // empty images at the width and height limits
    build_file(f, 4096, 0, 8, 1, 0, 0, 0, 0); send_file(f);
    build_file(f, 0, 4096, 24, 0, 0, 0, 0, 1); send_file(f);
    // truncation, and two lone bytes
    build_file(f, 2, 2, 16, 0, 3, 0, 5, 0); send_file(f);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    wait_drained();
  endtask

  task automatic test_random(int n_bytes);
    logic [7:0] f[$];
    int sent, dmg, bpp;
    sent = 0;
    while (sent < n_bytes) begin
      case ($urandom_range(9))
        0: begin
          f.delete();
          repeat ($urandom_range(1, 60)) f.insert(f.size(), 8'($urandom));
        end
        default: begin
          bpp = 8 * $urandom_range(1, 4);
          dmg = ($urandom_range(5) == 0) ? $urandom_range(1, 9) : 0;
          build_file(f, $urandom_range(0, 5), $urandom_range(0, 4), bpp,
                     $urandom_range(0, 3), $urandom_range(0, 6), dmg,
                     ($urandom_range(6) == 0) ? $urandom_range(1, 30) : 0,
                     $urandom_range(0, 3));
        end
      endcase
      send_file(f);
      sent += f.size();
    end
    wait_drained();
  endtask

  // Hold the receiver off so the result queue fills and backs up the input
  task automatic test_backpressure();
    logic [7:0] f[$];
    hold_cycles = 300;
    build_file(f, 6, 3, 32, 0, 0, 0, 0, 0);
    send_file(f);
    wait_drained();
  endtask

  initial begin
    clear_decoder();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_idle_pct = 31; recv_idle_pct = 53;
    test_directed();
    send_idle_pct = 53; recv_idle_pct = 31;
    test_random(60);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_backpressure();
    test_random(40);
    wait_drained();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && expected_beats.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== filelist.f =====
+incdir+src
src/bmp_pkg.sv
src/bmp_front.sv
src/bmp_queue.sv
src/bmp_stream_parser.sv
bench/tb_bmp_stream_parser.sv
